### hdl/scc_pkg.sv
// Shared types and constants for the strongly connected component search block.
`timescale 1ns / 1ps
package scc_pkg;
	localparam int unsigned NODE_W  = 6;
	localparam int unsigned COUNT_W = 7;
	localparam logic REQ_EDGE   = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [NODE_W-1:0]   edge_source;
		logic [NODE_W-1:0]   edge_target;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0]   node;
		logic [NODE_W-1:0]   component;
		logic                last;
	} res_t;
endpackage

### hdl/scc_req_if.sv
// Valid/ready channel interface for request beats.
`timescale 1ns / 1ps
interface scc_req_if;
	import scc_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/scc_res_if.sv
// Valid/ready channel interface for result beats.
`timescale 1ns / 1ps
interface scc_res_if;
	import scc_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/strongly_connected_order.sv
// Top level: edge loading into an adjacency memory and iterative Tarjan search.
// Usage:
//   req (sink): edge beats (req_type=0) set one adjacency bit, one beat per cycle.
//   A finish beat (req_type=1) starts the search over node_count nodes
//   (saturated to MAX_NODES); req.ready stays low until the run and the clearing
//   pass after it are complete.
//   res (source): one beat per node, in pop order, with component index and
//   last set on the final node. Nothing is emitted when node_count is zero.
//   cfg_we/cfg_data write node_count; write only while idle.
// Structure: the search is a sequencer around the adjacency and mark memories,
//   each with a registered read. Every adjacency bit examined passes a scan
//   read and a scan state; each node adds a root check, enter, final scan
//   check, finish, a pop read and pop per pop and a return read, return and
//   load per return, and stalls at res lengthen a run. A clearing pass over
//   all MAX_NODES rows then zeroes the matrix and marks.
// Reset: arst_n clears control state and starts the clearing pass; requests
//   are held off until it ends. A stalled res holds the pop sequencer in
//   place, so no beat is lost.
`timescale 1ns / 1ps
module strongly_connected_order #(
	parameter int unsigned MAX_NODES = 64
) (
	input  logic clk,
	input  logic arst_n,
	scc_req_if.sink   req,
	scc_res_if.source res,
	input  logic cfg_we,
	input  logic [scc_pkg::COUNT_W-1:0] cfg_data
);
	import scc_pkg::*;

	localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned VW = AW + 1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ROOT, S_ROOT_RD, S_ENTER, S_SCAN_RD, S_SCAN,
		S_FINISH, S_POP_RD, S_POP, S_RET_RD, S_RET, S_RET_LD
	} state_t;

	state_t state_q;
	// memories
	logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
	logic [VW-1:0]   vis_mem [MAX_NODES];
	logic [VW-1:0]   low_mem [MAX_NODES];
	logic            ons_mem [MAX_NODES];
	logic [AW-1:0]   nst_mem [MAX_NODES];
	logic [2*AW-1:0] cst_mem [MAX_NODES];

	logic [MAX_NODES-1:0] adj_rd_q;
	logic [VW-1:0]   vis_rd_q, low_rd_q;
	logic            ons_rd_q;
	logic [AW-1:0]   nst_rd_q;
	logic [2*AW-1:0] cst_rd_q;

	logic [COUNT_W-1:0] node_count_q;
	logic [VW-1:0] n_q, root_q, cursor_q, nst_top_q, cdepth_q, pops_q;
	logic [VW-1:0] visit_q, low_u_q, vis_u_q;
	logic [AW-1:0] u_q;
	logic [NODE_W-1:0] comp_q;
	logic          res_valid_q;
	res_t          res_q;

	// one shared address for all mark reads
	logic [AW-1:0] rd_addr;
	logic          we_adj, we_vis, we_low, we_ons, we_nst, we_cst;
	logic [AW-1:0] wa_adj, wa_vis, wa_low, wa_ons, wa_nst, wa_cst;
	logic [MAX_NODES-1:0] wd_adj;
	logic [VW-1:0] wd_vis, wd_low;
	logic          wd_ons;
	logic [AW-1:0] wd_nst;
	logic [2*AW-1:0] wd_cst;
	logic [AW-1:0] adj_raddr, nst_raddr, cst_raddr;

	// edge write pipeline: row read at acceptance, written next cycle
	logic                 edge_s1, edge_s2;
	logic [AW-1:0]        edge_row_s1, edge_col_s1, edge_row_s2;
	logic [MAX_NODES-1:0] row_s2, row_fwd, edge_wd;

	logic edge_ok;
	logic adj_bit;
	logic descend;
	logic pop_fire;

	assign edge_ok = (COUNT_W'(req.data.edge_source) < COUNT_W'(MAX_NODES))
		&& (COUNT_W'(req.data.edge_target) < COUNT_W'(MAX_NODES));
	assign req.ready = (state_q == S_IDLE);
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	assign adj_bit  = adj_rd_q[cursor_q[AW-1:0]];
	assign descend  = (state_q == S_SCAN) && adj_bit && (vis_rd_q == '0);
	assign pop_fire = (state_q == S_POP) && (!res_valid_q || res.ready);

	always_comb begin
		row_fwd = adj_rd_q;
		// forward a write to the same row in the previous cycle
		if (edge_s2 && edge_row_s2 == edge_row_s1) row_fwd = row_s2;
	end
	assign edge_wd = row_fwd | (MAX_NODES'(1) << edge_col_s1);

	always_ff @(posedge clk) begin
		if (we_adj) adj_mem[wa_adj] <= wd_adj;
		if (we_vis) vis_mem[wa_vis] <= wd_vis;
		if (we_low) low_mem[wa_low] <= wd_low;
		if (we_ons) ons_mem[wa_ons] <= wd_ons;
		if (we_nst) nst_mem[wa_nst] <= wd_nst;
		if (we_cst) cst_mem[wa_cst] <= wd_cst;
		adj_rd_q <= adj_mem[adj_raddr];
		vis_rd_q <= vis_mem[rd_addr];
		low_rd_q <= low_mem[rd_addr];
		ons_rd_q <= ons_mem[rd_addr];
		nst_rd_q <= nst_mem[nst_raddr];
		cst_rd_q <= cst_mem[cst_raddr];
	end

	// memory control
	always_comb begin
		we_adj = 1'b0; we_vis = 1'b0; we_low = 1'b0; we_ons = 1'b0;
		we_nst = 1'b0; we_cst = 1'b0;
		wa_adj = edge_row_s1; wd_adj = edge_wd;
		wa_vis = u_q; wd_vis = visit_q;
		wa_low = u_q; wd_low = visit_q;
		wa_ons = u_q; wd_ons = 1'b1;
		wa_nst = nst_top_q[AW-1:0]; wd_nst = u_q;
		wa_cst = cdepth_q[AW-1:0]; wd_cst = {u_q, cursor_q[AW-1:0]};
		rd_addr = cursor_q[AW-1:0];
		adj_raddr = u_q;
		nst_raddr = AW'(nst_top_q - VW'(1));
		cst_raddr = AW'(cdepth_q - VW'(1));
		unique case (state_q)
			S_CLEAR: begin
				we_adj = 1'b1; we_vis = 1'b1; we_low = 1'b1; we_ons = 1'b1;
				wa_adj = root_q[AW-1:0]; wa_vis = root_q[AW-1:0];
				wa_low = root_q[AW-1:0]; wa_ons = root_q[AW-1:0];
				wd_adj = '0; wd_vis = '0; wd_low = '0; wd_ons = 1'b0;
			end
			S_IDLE: begin
				we_adj = edge_s1;
				adj_raddr = req.data.edge_source[AW-1:0];
			end
			S_ROOT: rd_addr = root_q[AW-1:0];
			S_ENTER: begin
				we_vis = 1'b1; we_low = 1'b1; we_ons = 1'b1;
				we_nst = (nst_top_q < VW'(MAX_NODES));
			end
			S_SCAN: begin
				// parent's low link is kept in memory while a child is searched
				we_low = descend; wd_low = low_u_q;
				we_cst = descend && (cdepth_q < VW'(MAX_NODES));
			end
			S_POP: begin
				we_ons = pop_fire; wd_ons = 1'b0; wa_ons = nst_rd_q;
			end
			S_RET: rd_addr = cst_rd_q[2*AW-1:AW];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		row_s2      <= edge_wd;
		edge_row_s1 <= req.data.edge_source[AW-1:0];
		edge_col_s1 <= req.data.edge_target[AW-1:0];
		edge_row_s2 <= edge_row_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_s1 <= 1'b0;
			edge_s2 <= 1'b0;
		end else begin
			edge_s1 <= req.valid && req.ready && req.data.req_type == REQ_EDGE && edge_ok;
			edge_s2 <= edge_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			node_count_q <= COUNT_W'(64);
			root_q <= '0; cursor_q <= '0; n_q <= '0; nst_top_q <= '0; cdepth_q <= '0;
			visit_q <= VW'(1); comp_q <= '0; pops_q <= '0; u_q <= '0;
			low_u_q <= '0; vis_u_q <= '0;
			res_valid_q <= 1'b0; res_q <= '0;
		end else begin
			if (cfg_we) node_count_q <= cfg_data;
			res_valid_q <= pop_fire || (res_valid_q && !res.ready);
			unique case (state_q)
				S_CLEAR: begin
					if (root_q == VW'(MAX_NODES - 1)) begin
						root_q <= '0;
						state_q <= S_IDLE;
					end else root_q <= root_q + VW'(1);
				end
				S_IDLE: begin
					if (req.valid && req.ready && req.data.req_type == REQ_FINISH) begin
						n_q <= (node_count_q > COUNT_W'(MAX_NODES)) ? VW'(MAX_NODES)
							: VW'(node_count_q);
						root_q <= '0; nst_top_q <= '0; cdepth_q <= '0;
						visit_q <= VW'(1); comp_q <= '0; pops_q <= '0;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (root_q >= n_q) begin
						root_q <= '0;
						state_q <= S_CLEAR;
					end else state_q <= S_ROOT_RD;
				end
				S_ROOT_RD: begin
					if (vis_rd_q != '0) begin
						root_q <= root_q + VW'(1);
						state_q <= S_ROOT;
					end else begin
						u_q <= root_q[AW-1:0];
						state_q <= S_ENTER;
					end
				end
				S_ENTER: begin
					vis_u_q <= visit_q; low_u_q <= visit_q;
					visit_q <= visit_q + VW'(1);
					if (nst_top_q < VW'(MAX_NODES)) nst_top_q <= nst_top_q + VW'(1);
					cursor_q <= '0;
					state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: begin
					if (cursor_q >= n_q) state_q <= S_FINISH;
					else state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (descend) begin
						if (cdepth_q < VW'(MAX_NODES)) cdepth_q <= cdepth_q + VW'(1);
						u_q <= cursor_q[AW-1:0];
						state_q <= S_ENTER;
					end else begin
						if (adj_bit && ons_rd_q && vis_rd_q < low_u_q) low_u_q <= vis_rd_q;
						cursor_q <= cursor_q + VW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_FINISH: begin
					if (low_u_q == vis_u_q) begin
						state_q <= S_POP_RD;
					end else state_q <= S_RET_RD;
				end
				S_POP_RD: begin
					if (nst_top_q == '0) begin
						comp_q <= comp_q + NODE_W'(1);
						state_q <= S_RET_RD;
					end else state_q <= S_POP;
				end
				S_POP: begin
					if (pop_fire) begin
						res_q.node <= NODE_W'(nst_rd_q);
						res_q.component <= comp_q;
						res_q.last <= (pops_q + VW'(1) == n_q);
						pops_q <= pops_q + VW'(1);
						nst_top_q <= nst_top_q - VW'(1);
						if (nst_rd_q == u_q) begin
							comp_q <= comp_q + NODE_W'(1);
							state_q <= S_RET_RD;
						end else state_q <= S_POP_RD;
					end
				end
				S_RET_RD: begin
					if (cdepth_q == '0) begin
						root_q <= root_q + VW'(1);
						state_q <= S_ROOT;
					end else state_q <= S_RET;
				end
				S_RET: begin
					// low_u_q still holds the child's low link
					u_q <= cst_rd_q[2*AW-1:AW];
					cursor_q <= VW'(cst_rd_q[AW-1:0]) + VW'(1);
					cdepth_q <= cdepth_q - VW'(1);
					state_q <= S_RET_LD;
				end
				S_RET_LD: begin
					if (low_rd_q < low_u_q) low_u_q <= low_rd_q;
					vis_u_q <= vis_rd_q;
					state_q <= S_SCAN_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.data))
		else $error("result beat changed under stall");
	a_edge_idle: assert property (@(posedge clk) disable iff (!arst_n)
		edge_s1 |-> state_q == S_IDLE)
		else $error("edge write outside idle");
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && state_q == S_IDLE |-> res.data.last)
		else $error("pending beat in idle is not the final one");
`endif
endmodule
